// ===== rtl/ttc_pkg.sv =====
package ttc_pkg;

  // Character codes with a meaning of their own
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Configuration register indexes (byte address 4*index)
  localparam logic [1:0] REG_COLUMNS  = 2'd0;
  localparam logic [1:0] REG_ROWS     = 2'd1;
  localparam logic [1:0] REG_FORE     = 2'd2;
  localparam logic [1:0] REG_BACK     = 2'd3;

  // Width of the APB address
  localparam int unsigned AddrW = 4;

  // Screen commands on the result channel
  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_SCROLL  = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_REFUSED = 2'd3
  } ttc_cmd_e;

  // Classified input item
  typedef enum logic [1:0] {
    KIND_PRINT,
    KIND_NEWLINE,
    KIND_BACKSPACE,
    KIND_CLEAR
  } ttc_kind_e;

  typedef struct packed {
    ttc_kind_e  kind;
    logic [7:0] glyph;
  } ttc_item_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [7:0] rows;
    logic [3:0] fore;
    logic [3:0] back;
  } ttc_cfg_t;

  typedef struct packed {
    ttc_cmd_e   command;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] glyph;
    logic [3:0] fore;
    logic [3:0] back;
    logic       last;
  } ttc_result_t;

endpackage

// ===== rtl/ttc_front.sv =====
module ttc_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [7:0]        char_code_i,
  output logic              push_o,
  output ttc_pkg::ttc_item_t item_o,
  input  logic              full_i
);

  // Take an item whenever the queue has room
  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & ~full_i;

  always_comb begin
    item_o.glyph = char_code_i;
    priority if (op_i) begin
      item_o.kind = ttc_pkg::KIND_CLEAR;
    end else if (char_code_i == ttc_pkg::CH_NEWLINE) begin
      item_o.kind = ttc_pkg::KIND_NEWLINE;
    end else if (char_code_i == ttc_pkg::CH_BACKSPACE) begin
      item_o.kind = ttc_pkg::KIND_BACKSPACE;
    end else begin
      item_o.kind = ttc_pkg::KIND_PRINT;
    end
  end

endmodule

// ===== rtl/ttc_fifo.sv =====
module ttc_fifo #(
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ttc_pkg::ttc_item_t wr_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ttc_pkg::ttc_item_t rd_item_o,
  output logic [CntW-1:0]    count_o
);

  ttc_pkg::ttc_item_t entry_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign valid_o   = (count_q != '0);
  assign rd_item_o = entry_q[rd_ptr_q];
  assign count_o   = count_q;
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ===== rtl/ttc_back.sv =====
module ttc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ttc_pkg::ttc_cfg_t    cfg_i,
  input  logic                 item_valid_i,
  input  ttc_pkg::ttc_item_t   item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ttc_pkg::ttc_result_t out_o
);

  logic [7:0]           col_q, col_d;
  logic [7:0]           row_q, row_d;
  logic                 pend_q, pend_d;
  logic                 valid_q, valid_d;
  ttc_pkg::ttc_result_t res_q, res_d;

  logic                 out_free, pop;
  logic [7:0]           cols_last, rows_last, cc, cr;
  logic                 emit, scroll_next;
  ttc_pkg::ttc_result_t first;
  ttc_pkg::ttc_result_t scroll_res;

  // A zero register counts as one
  assign cols_last = (cfg_i.columns == 8'd0) ? 8'd0 : cfg_i.columns - 8'd1;
  assign rows_last = (cfg_i.rows == 8'd0) ? 8'd0 : cfg_i.rows - 8'd1;
  assign cc = (col_q > cols_last) ? cols_last : col_q;
  assign cr = (row_q > rows_last) ? rows_last : row_q;

  assign out_free = ~valid_q | out_ready_i;
  assign pop      = item_valid_i & out_free & ~pend_q;
  assign pop_o    = pop;

  always_comb begin
    scroll_res         = '0;
    scroll_res.command = ttc_pkg::CMD_SCROLL;
    scroll_res.last    = 1'b1;
  end

  // Cursor step and first result of the item at the queue head
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    emit        = 1'b0;
    scroll_next = 1'b0;
    first       = '0;
    first.last  = 1'b1;
    unique case (item_i.kind)
      ttc_pkg::KIND_CLEAR: begin
        col_d         = 8'd0;
        row_d         = 8'd0;
        emit          = 1'b1;
        first.command = ttc_pkg::CMD_CLEAR;
      end
      ttc_pkg::KIND_NEWLINE: begin
        col_d = 8'd0;
        if (cr == rows_last) begin
          row_d         = rows_last;
          emit          = 1'b1;
          first.command = ttc_pkg::CMD_SCROLL;
        end else begin
          row_d = cr + 8'd1;
        end
      end
      ttc_pkg::KIND_BACKSPACE: begin
        emit = 1'b1;
        if (cc == 8'd0 && cr == 8'd0) begin
          col_d         = cc;
          row_d         = cr;
          first.command = ttc_pkg::CMD_REFUSED;
        end else begin
          if (cc == 8'd0) begin
            col_d = cols_last;
            row_d = cr - 8'd1;
          end else begin
            col_d = cc - 8'd1;
            row_d = cr;
          end
          first.command = ttc_pkg::CMD_DRAW;
          first.column  = col_d;
          first.row     = row_d;
          first.glyph   = ttc_pkg::CH_SPACE;
          first.fore    = cfg_i.fore;
          first.back    = cfg_i.back;
        end
      end
      ttc_pkg::KIND_PRINT: begin
        emit          = 1'b1;
        first.command = ttc_pkg::CMD_DRAW;
        first.column  = cc;
        first.row     = cr;
        first.glyph   = item_i.glyph;
        first.fore    = cfg_i.fore;
        first.back    = cfg_i.back;
        if (cc == cols_last) begin
          col_d = 8'd0;
          if (cr == rows_last) begin
            row_d       = rows_last;
            scroll_next = 1'b1;
            first.last  = 1'b0;
          end else begin
            row_d = cr + 8'd1;
          end
        end else begin
          col_d = cc + 8'd1;
          row_d = cr;
        end
      end
      default: begin
        col_d = col_q;
      end
    endcase
  end

  // Output stage: a pending scroll goes before any new item
  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    pend_d  = pend_q;
    if (out_free) begin
      if (pend_q) begin
        valid_d = 1'b1;
        res_d   = scroll_res;
        pend_d  = 1'b0;
      end else if (pop && emit) begin
        valid_d = 1'b1;
        res_d   = first;
        pend_d  = scroll_next;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= 8'd0;
      row_q   <= 8'd0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (pop) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

// ===== rtl/text_terminal_cursor.sv =====
// Channel     | Direction | Handshake                 | Payload
// ------------+-----------+---------------------------+--------------------------------------
// s_axis      | in        | s_axis_tvalid/tready      | tuser: op; tdata: char_code
// m_axis      | out       | m_axis_tvalid/tready      | tuser: command; tdata: cell; tlast
// APB config  | in        | psel/penable/pwrite       | paddr, pwdata, prdata
//
// One item a cycle in steady state: the front stage classifies and queues
// each transaction, the back stage retires one queued item per cycle.
// A printable character that wraps past the last row gives two results in
// the back stage (draw, then scroll) through its single output register.
// Reset clears the cursor, the queue and the output stage; the registers
// return to 80 columns, 25 rows, colour 15 on 0.
// An output stall holds the back stage; input keeps flowing until the
// queue of QUEUE_DEPTH entries fills.
module text_terminal_cursor #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]  s_axis_tuser,   // [0] op

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] column, [15:8] row, [23:16] glyph,
                                      // [27:24] fore_color, [31:28] back_color
  output logic [1:0]  m_axis_tuser,   // [1:0] command
  output logic        m_axis_tlast,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ttc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  ttc_pkg::ttc_cfg_t    cfg_q;
  logic                 cfg_wr;
  logic [1:0]           reg_idx;

  logic                 push, full, pop, q_valid;
  ttc_pkg::ttc_item_t   wr_item, rd_item;
  logic [CntW-1:0]      q_count;
  ttc_pkg::ttc_result_t res;

  // Configuration registers: write on the access phase, no wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns <= 8'd80;
      cfg_q.rows    <= 8'd25;
      cfg_q.fore    <= 4'd15;
      cfg_q.back    <= 4'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ttc_pkg::REG_COLUMNS: cfg_q.columns <= pwdata[7:0];
        ttc_pkg::REG_ROWS:    cfg_q.rows    <= pwdata[7:0];
        ttc_pkg::REG_FORE:    cfg_q.fore    <= pwdata[3:0];
        ttc_pkg::REG_BACK:    cfg_q.back    <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ttc_pkg::REG_COLUMNS: prdata = {24'd0, cfg_q.columns};
      ttc_pkg::REG_ROWS:    prdata = {24'd0, cfg_q.rows};
      ttc_pkg::REG_FORE:    prdata = {28'd0, cfg_q.fore};
      ttc_pkg::REG_BACK:    prdata = {28'd0, cfg_q.back};
    endcase
  end

  // Front: classify and queue
  ttc_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser[0]),
    .char_code_i (s_axis_tdata),
    .push_o      (push),
    .item_o      (wr_item),
    .full_i      (full)
  );

  ttc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_item_i (wr_item),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .rd_item_o (rd_item),
    .count_o   (q_count)
  );

  // Back: move the cursor and issue screen commands
  ttc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (rd_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tuser = res.command;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {res.back, res.fore, res.glyph, res.row, res.column};

  // Queue occupancy never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // Only a draw can be followed by a second result of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ttc_pkg::CMD_DRAW)
    else $error("non-final result that is not a draw");

  // The scroll that completes a wrapped draw follows straight after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tlast && m_axis_tuser == ttc_pkg::CMD_SCROLL)
    else $error("missing scroll after wrapped draw");

  // A clear always stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ttc_pkg::CMD_CLEAR |-> m_axis_tlast)
    else $error("clear not marked last");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass after the last expected command before a register write.
  // A newline that stays on screen makes no command, so only this settle wait covers it.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Receiver hold-off for the pressure phase, long enough to fill the queue
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 75;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;

  logic        m_axis_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ttc_pkg::AddrW-1:0]     paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  text_terminal_cursor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the screen geometry, colours and cursor
  logic [7:0] scr_cols, scr_rows;
  logic [3:0] ink, paper;
  logic [7:0] cur_col, cur_row;

  // Screen commands still owed by the block, oldest first
  ttc_pkg::ttc_result_t screen_cmds_due[$];

  int unsigned errors = 0;

  // Idling control shared between stimulus and receiver
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_granted = 0;
  int unsigned rx_wait = 0;

  // Directed stimulus: register writes and characters, some with the command typed in
  typedef struct {
    bit                   is_write;
    logic [1:0]           reg_idx;
    logic [7:0]           value;
    logic                 op;
    logic [7:0]           ch;
    bit                   typed;
    ttc_pkg::ttc_result_t res;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic ttc_pkg::ttc_result_t make_cmd(ttc_pkg::ttc_cmd_e c, int unsigned col,
                                                    int unsigned row, int unsigned glyph,
                                                    int unsigned fore, int unsigned back,
                                                    bit last);
    ttc_pkg::ttc_result_t r;
    r.command = c;
    r.column  = col[7:0];
    r.row     = row[7:0];
    r.glyph   = glyph[7:0];
    r.fore    = fore[3:0];
    r.back    = back[3:0];
    r.last    = last;
    return r;
  endfunction

  // Move to column 0 of the next row; tell whether the screen has to scroll
  function automatic bit feed_line(int unsigned nrows);
    cur_col = '0;
    if (int'(cur_row) + 1 >= int'(nrows)) begin
      cur_row = 8'(nrows - 1);
      return 1'b1;
    end
    cur_row = cur_row + 8'd1;
    return 1'b0;
  endfunction

  // Work out the commands one accepted character or clear request causes
  function automatic void advance_cursor(logic op, logic [7:0] ch);
    int unsigned          ncols, nrows;
    bit                   scrolled;
    ttc_pkg::ttc_result_t draw;
    ncols = (scr_cols == 0) ? 1 : scr_cols;
    nrows = (scr_rows == 0) ? 1 : scr_rows;
    scrolled = 1'b0;
    if (op) begin
      cur_col = '0;
      cur_row = '0;
      screen_cmds_due.push_back(make_cmd(ttc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1'b1));
    end else begin
      // pull the cursor back onto a screen that has shrunk
      if (cur_col >= ncols) cur_col = 8'(ncols - 1);
      if (cur_row >= nrows) cur_row = 8'(nrows - 1);
      if (ch == ttc_pkg::CH_NEWLINE) begin
        if (feed_line(nrows))
          screen_cmds_due.push_back(make_cmd(ttc_pkg::CMD_SCROLL, 0, 0, 0, 0, 0, 1'b1));
      end else if (ch == ttc_pkg::CH_BACKSPACE) begin
        if (cur_col == 0 && cur_row == 0) begin
          screen_cmds_due.push_back(make_cmd(ttc_pkg::CMD_REFUSED, 0, 0, 0, 0, 0, 1'b1));
        end else begin
          if (cur_col == 0) begin
            cur_row = cur_row - 8'd1;
            cur_col = 8'(ncols - 1);
          end else begin
            cur_col = cur_col - 8'd1;
          end
          screen_cmds_due.push_back(make_cmd(ttc_pkg::CMD_DRAW, cur_col, cur_row,
                                             ttc_pkg::CH_SPACE, ink, paper, 1'b1));
        end
      end else begin
        draw = make_cmd(ttc_pkg::CMD_DRAW, cur_col, cur_row, ch, ink, paper, 1'b1);
        if (int'(cur_col) + 1 >= int'(ncols)) scrolled = feed_line(nrows);
        else cur_col = cur_col + 8'd1;
        draw.last = !scrolled;
        screen_cmds_due.push_back(draw);
        if (scrolled)
          screen_cmds_due.push_back(make_cmd(ttc_pkg::CMD_SCROLL, 0, 0, 0, 0, 0, 1'b1));
      end
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3: return 8'($urandom_range(2, 255));
      default: return 8'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return ttc_pkg::CH_NEWLINE;
      2, 3: return ttc_pkg::CH_BACKSPACE;
      4, 5, 6: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
    errors++;
  endtask

  // Drop valid and wait until every owed command has come out, then let the
  // back stage drain anything that made no command
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (screen_cmds_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ttc_pkg::AddrW'({idx, 2'b00});
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ttc_pkg::REG_COLUMNS: scr_cols = value;
      ttc_pkg::REG_ROWS:    scr_rows = value;
      ttc_pkg::REG_FORE:    ink      = value[3:0];
      ttc_pkg::REG_BACK:    paper    = value[3:0];
      default: ;
    endcase
  endtask

  // Offer one transaction, now and then after a random gap; predict once it is taken.
  // A typed row replaces the predicted command by the one written in the table.
  task automatic send_char(logic op, logic [7:0] ch, bit typed, ttc_pkg::ttc_result_t res);
    int unsigned gap, depth;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 9) < 3) gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= ch;
    s_tuser[0] <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    depth = screen_cmds_due.size();
    advance_cursor(op, ch);
    if (typed) begin
      while (screen_cmds_due.size() > depth) void'(screen_cmds_due.pop_back());
      screen_cmds_due.push_back(res);
    end
  endtask

  function automatic void add_write(logic [1:0] idx, logic [7:0] value);
    plan_row_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.value    = value;
    r.op       = 1'b0;
    r.ch       = '0;
    r.typed    = 1'b0;
    r.res      = make_cmd(ttc_pkg::CMD_DRAW, 0, 0, 0, 0, 0, 1'b0);
    plan.push_back(r);
  endfunction

  function automatic void add_char(logic op, logic [7:0] ch, bit typed,
                                   ttc_pkg::ttc_result_t res);
    plan_row_t r;
    r.is_write = 1'b0;
    r.reg_idx  = '0;
    r.value    = '0;
    r.op       = op;
    r.ch       = ch;
    r.typed    = typed;
    r.res      = res;
    plan.push_back(r);
  endfunction

  // Receiver: random back-pressure, a long hold-off when asked, calm stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_requests != hold_granted) begin
      hold_granted <= hold_requests;
      rx_wait      <= HOLD_CYCLES - 1;
      m_tready     <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
      rx_wait  <= pick_gap() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check every command taken against the oldest one owed
  always @(posedge clk_i) begin
    ttc_pkg::ttc_result_t want;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (screen_cmds_due.size() == 0) begin
        report_mismatch("unexpected command", m_axis_tuser, -1);
      end else begin
        want = screen_cmds_due.pop_front();
        if (m_axis_tuser != want.command)
          report_mismatch("command", m_axis_tuser, want.command);
        if (m_axis_tdata[7:0] != want.column)
          report_mismatch("column", m_axis_tdata[7:0], want.column);
        if (m_axis_tdata[15:8] != want.row)
          report_mismatch("row", m_axis_tdata[15:8], want.row);
        if (m_axis_tdata[23:16] != want.glyph)
          report_mismatch("glyph", m_axis_tdata[23:16], want.glyph);
        if (m_axis_tdata[27:24] != want.fore)
          report_mismatch("fore_color", m_axis_tdata[27:24], want.fore);
        if (m_axis_tdata[31:28] != want.back)
          report_mismatch("back_color", m_axis_tdata[31:28], want.back);
        if (m_axis_tlast != want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  initial begin : stimulus
    ttc_pkg::ttc_result_t none;
    none = make_cmd(ttc_pkg::CMD_DRAW, 0, 0, 0, 0, 0, 1'b0);

    scr_cols = 8'd80;
    scr_rows = 8'd25;
    ink      = 4'd15;
    paper    = 4'd0;
    cur_col  = '0;
    cur_row  = '0;

    // At reset: 80 x 25, colour 15 on 0, cursor at the origin
    add_char(1'b0, ttc_pkg::CH_BACKSPACE, 1'b1,
             make_cmd(ttc_pkg::CMD_REFUSED, 0, 0, 0, 0, 0, 1'b1));
    add_char(1'b0, 8'h41, 1'b1, make_cmd(ttc_pkg::CMD_DRAW, 0, 0, 8'h41, 15, 0, 1'b1));
    add_char(1'b0, ttc_pkg::CH_BACKSPACE, 1'b1,
             make_cmd(ttc_pkg::CMD_DRAW, 0, 0, ttc_pkg::CH_SPACE, 15, 0, 1'b1));
    add_char(1'b0, 8'h00, 1'b1, make_cmd(ttc_pkg::CMD_DRAW, 0, 0, 8'h00, 15, 0, 1'b1));
    add_char(1'b0, 8'hFF, 1'b1, make_cmd(ttc_pkg::CMD_DRAW, 1, 0, 8'hFF, 15, 0, 1'b1));
    add_char(1'b0, ttc_pkg::CH_NEWLINE, 1'b0, none);
    // backspace from column 0 wraps to the end of the row above
    add_char(1'b0, ttc_pkg::CH_BACKSPACE, 1'b1,
             make_cmd(ttc_pkg::CMD_DRAW, 79, 0, ttc_pkg::CH_SPACE, 15, 0, 1'b1));
    add_char(1'b0, 8'h42, 1'b0, none);
    add_char(1'b0, 8'h43, 1'b0, none);
    add_char(1'b1, 8'hFF, 1'b1, make_cmd(ttc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1'b1));
    add_char(1'b0, 8'h43, 1'b0, none);
    add_char(1'b0, 8'h44, 1'b0, none);
    // zero geometry acts as one cell; the cursor is clamped back onto it
    add_write(ttc_pkg::REG_COLUMNS, 8'd0);
    add_write(ttc_pkg::REG_ROWS, 8'd0);
    add_char(1'b0, 8'h45, 1'b0, none);
    add_char(1'b0, ttc_pkg::CH_NEWLINE, 1'b1,
             make_cmd(ttc_pkg::CMD_SCROLL, 0, 0, 0, 0, 0, 1'b1));
    add_char(1'b0, ttc_pkg::CH_BACKSPACE, 1'b1,
             make_cmd(ttc_pkg::CMD_REFUSED, 0, 0, 0, 0, 0, 1'b1));
    add_write(ttc_pkg::REG_COLUMNS, 8'd255);
    add_write(ttc_pkg::REG_ROWS, 8'd255);
    add_write(ttc_pkg::REG_FORE, 8'd0);
    add_write(ttc_pkg::REG_BACK, 8'd15);
    add_char(1'b1, 8'h00, 1'b1, make_cmd(ttc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1'b1));
    add_char(1'b0, 8'h7E, 1'b1, make_cmd(ttc_pkg::CMD_DRAW, 0, 0, 8'h7E, 0, 15, 1'b1));
    // 3 x 2 screen: wraps, then a scroll on the wrap past the bottom row
    add_write(ttc_pkg::REG_COLUMNS, 8'd3);
    add_write(ttc_pkg::REG_ROWS, 8'd2);
    for (int c = 8'h61; c <= 8'h66; c++) add_char(1'b0, 8'(c), 1'b0, none);
    add_char(1'b0, ttc_pkg::CH_NEWLINE, 1'b1,
             make_cmd(ttc_pkg::CMD_SCROLL, 0, 0, 0, 0, 0, 1'b1));
    add_char(1'b0, ttc_pkg::CH_BACKSPACE, 1'b1,
             make_cmd(ttc_pkg::CMD_DRAW, 2, 0, ttc_pkg::CH_SPACE, 0, 15, 1'b1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].reg_idx, plan[i].value);
      else send_char(plan[i].op, plan[i].ch, plan[i].typed, plan[i].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(ttc_pkg::REG_COLUMNS, 8'd1);
          write_reg(ttc_pkg::REG_ROWS, 8'd1);
          write_reg(ttc_pkg::REG_FORE, 8'd15);
          write_reg(ttc_pkg::REG_BACK, 8'd15);
        end
        1: begin
          write_reg(ttc_pkg::REG_COLUMNS, 8'd255);
          write_reg(ttc_pkg::REG_ROWS, 8'd2);
          write_reg(ttc_pkg::REG_FORE, 8'd0);
          write_reg(ttc_pkg::REG_BACK, 8'd0);
        end
        default: begin
          write_reg(ttc_pkg::REG_COLUMNS, pick_dim());
          write_reg(ttc_pkg::REG_ROWS, pick_dim());
          write_reg(ttc_pkg::REG_FORE, 8'($urandom_range(0, 15)));
          write_reg(ttc_pkg::REG_BACK, 8'($urandom_range(0, 15)));
        end
      endcase
      tx_calm = (p == 2);
      rx_calm = (p == 2);
      // hold the receiver off while the sender keeps offering
      if (p == 4) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_char($urandom_range(0, 19) == 0, pick_char(), 1'b0, none);
    end

    wait_idle();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
